@@ hdl/bams_pkg.sv @@
`timescale 1ns / 1ps

package bams_pkg;

  localparam int ACC_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_BACKUP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TURN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIDESTEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PENALTY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FWD_SPD  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REV_SPD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_SPD = 3'd6;

  // Reset values of the registers.
  localparam logic [11:0] BACKUP_RST   = 12'd150;
  localparam logic [8:0]  TURN_RST     = 9'd90;
  localparam logic [11:0] SIDESTEP_RST = 12'd250;
  localparam logic [11:0] PENALTY_RST  = 12'd150;
  localparam logic [8:0]  FWD_SPD_RST  = 9'd150;
  localparam logic [8:0]  REV_SPD_RST  = 9'd50;
  localparam logic [8:0]  TURN_SPD_RST = 9'd25;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_FWD  = 3'd1,
    PH_REV  = 3'd2,
    PH_AWAY = 3'd3,
    PH_SIDE = 3'd4,
    PH_BACK = 3'd5
  } phase_t;

  typedef struct packed {
    logic [11:0] backup_mm;
    logic [8:0]  turn_deg;
    logic [11:0] sidestep_mm;
    logic [11:0] progress_penalty_mm;
    logic [8:0]  forward_speed;
    logic [8:0]  reverse_speed;
    logic [8:0]  turn_speed;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic        bump_side;
    logic [15:0] goal;
  } ctl_state_t;

  typedef struct packed {
    logic signed [9:0] right_wheel;
    logic signed [9:0] left_wheel;
    logic              busy;
    logic              done;
    phase_t            phase;
  } result_t;

endpackage

@@ hdl/bump_avoid_motion_sequencer.sv @@
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// input     in_valid / in_ready   operation, target_distance, distance_delta,
//                                 angle_delta, bump_left, bump_right
// result    out_valid / out_ready right_wheel, left_wheel, busy_res, done_res, phase_out
// config    cfg_we                cfg_index, cfg_data (write only)
//
// Per item, the phase, progress and leg accumulators are updated at the accept edge through
// one saturating add and compare each, and that loop sets the rate of one item per clock while
// in_ready is high. The result is registered in the output queue when its item is accepted.
// A two-entry result queue lets the input side run on while a result waits; in_ready drops
// only when both entries are occupied. Synchronous reset returns the run state to idle,
// empties the queue and loads the register defaults.

module bump_avoid_motion_sequencer #(
  parameter int ACC_WIDTH = bams_pkg::ACC_WIDTH_DEF,
  parameter int FRAC_BITS = bams_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            operation,
  input  logic [15:0]                     target_distance,
  input  logic signed [15:0]              distance_delta,
  input  logic signed [15:0]              angle_delta,
  input  logic                            bump_left,
  input  logic                            bump_right,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [9:0]               right_wheel,
  output logic signed [9:0]               left_wheel,
  output logic                            busy_res,
  output logic                            done_res,
  output logic [2:0]                      phase_out,
  input  logic                            cfg_we,
  input  logic [bams_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bams_pkg::CFG_DATA_W-1:0] cfg_data
);

  bams_pkg::cfg_t       cfg;
  bams_pkg::ctl_state_t ctl, ctl_next;
  bams_pkg::result_t    res, out_item;
  logic signed [ACC_WIDTH-1:0] progress_acc, progress_acc_next;
  logic signed [ACC_WIDTH-1:0] leg_acc, leg_acc_next;
  logic accept;

  // Register file for the leg lengths, penalty and wheel speeds.
  bams_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Per-item sequencing: the whole step is combinational from the item and the run state.
  bams_step #(
    .ACC_WIDTH (ACC_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_step (
    .operation       (operation),
    .target_distance (target_distance),
    .distance_delta  (distance_delta),
    .angle_delta     (angle_delta),
    .bump_left       (bump_left),
    .bump_right      (bump_right),
    .cur             (ctl),
    .progress_acc    (progress_acc),
    .leg_acc         (leg_acc),
    .cfg             (cfg),
    .nxt             (ctl_next),
    .progress_next   (progress_acc_next),
    .leg_next        (leg_acc_next),
    .res             (res)
  );

  assign accept = in_valid && in_ready;

  // Run state advances only on accepted items; a tick while idle leaves it as it is.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.phase     <= bams_pkg::PH_IDLE;
      ctl.bump_side <= 1'b0;
      ctl.goal      <= '0;
      progress_acc  <= '0;
      leg_acc       <= '0;
    end else if (accept) begin
      ctl          <= ctl_next;
      progress_acc <= progress_acc_next;
      leg_acc      <= leg_acc_next;
    end
  end

  // The result of each accepted item is pushed in the same edge that updates the state.
  bams_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_item (res),
    .not_full  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  assign right_wheel = out_item.right_wheel;
  assign left_wheel  = out_item.left_wheel;
  assign busy_res    = out_item.busy;
  assign done_res    = out_item.done;
  assign phase_out   = out_item.phase;

`ifndef SYNTHESIS
  // A start with a zero target ends the run at once.
  a_zero_target_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !operation && (target_distance == 16'd0)
    |=> ctl.phase == bams_pkg::PH_IDLE)
    else $error("zero-target start did not leave the sequencer idle");

  // A tick while idle changes nothing.
  a_idle_tick_stable: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && operation && (ctl.phase == bams_pkg::PH_IDLE)
    |=> (ctl.phase == bams_pkg::PH_IDLE) && $stable(progress_acc) && $stable(leg_acc))
    else $error("tick while idle altered the run state");

  // Busy on a result agrees with the phase it reports, and done never comes with busy.
  a_busy_matches_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (busy_res == (phase_out != bams_pkg::PH_IDLE)) && !(done_res && busy_res))
    else $error("result busy flag disagrees with its phase");
`endif

endmodule

@@ hdl/bams_cfg.sv @@
`timescale 1ns / 1ps

module bams_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bams_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bams_pkg::CFG_DATA_W-1:0]     cfg_data,
  output bams_pkg::cfg_t                      cfg
);

  // Writes are masked to each register's width; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.backup_mm           <= bams_pkg::BACKUP_RST;
      cfg.turn_deg            <= bams_pkg::TURN_RST;
      cfg.sidestep_mm         <= bams_pkg::SIDESTEP_RST;
      cfg.progress_penalty_mm <= bams_pkg::PENALTY_RST;
      cfg.forward_speed       <= bams_pkg::FWD_SPD_RST;
      cfg.reverse_speed       <= bams_pkg::REV_SPD_RST;
      cfg.turn_speed          <= bams_pkg::TURN_SPD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bams_pkg::REG_BACKUP:   cfg.backup_mm           <= cfg_data;
        bams_pkg::REG_TURN:     cfg.turn_deg            <= cfg_data[8:0];
        bams_pkg::REG_SIDESTEP: cfg.sidestep_mm         <= cfg_data;
        bams_pkg::REG_PENALTY:  cfg.progress_penalty_mm <= cfg_data;
        bams_pkg::REG_FWD_SPD:  cfg.forward_speed       <= cfg_data[8:0];
        bams_pkg::REG_REV_SPD:  cfg.reverse_speed       <= cfg_data[8:0];
        bams_pkg::REG_TURN_SPD: cfg.turn_speed          <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/bams_step.sv @@
`timescale 1ns / 1ps

module bams_step #(
  parameter int ACC_WIDTH = bams_pkg::ACC_WIDTH_DEF,
  parameter int FRAC_BITS = bams_pkg::FRAC_BITS_DEF
) (
  input  logic                        operation,
  input  logic [15:0]                 target_distance,
  input  logic signed [15:0]          distance_delta,
  input  logic signed [15:0]          angle_delta,
  input  logic                        bump_left,
  input  logic                        bump_right,
  input  bams_pkg::ctl_state_t        cur,
  input  logic signed [ACC_WIDTH-1:0] progress_acc,
  input  logic signed [ACC_WIDTH-1:0] leg_acc,
  input  bams_pkg::cfg_t              cfg,
  output bams_pkg::ctl_state_t        nxt,
  output logic signed [ACC_WIDTH-1:0] progress_next,
  output logic signed [ACC_WIDTH-1:0] leg_next,
  output bams_pkg::result_t           res
);

  // Two guard bits: sums never wrap and the unsigned goal compares correctly.
  localparam int EW = ACC_WIDTH + 2;
  localparam logic signed [EW-1:0] ACC_MAX = signed'((EW'(1) << (ACC_WIDTH - 1)) - EW'(1));
  localparam logic signed [EW-1:0] ACC_MIN = -ACC_MAX - signed'(EW'(1));

  function automatic logic signed [ACC_WIDTH-1:0] sat_acc(input logic signed [EW-1:0] v);
    logic signed [ACC_WIDTH-1:0] r;
    if (v > ACC_MAX) begin
      r = ACC_MAX[ACC_WIDTH-1:0];
    end else if (v < ACC_MIN) begin
      r = ACC_MIN[ACC_WIDTH-1:0];
    end else begin
      r = v[ACC_WIDTH-1:0];
    end
    return r;
  endfunction

  logic signed [EW-1:0] d_ext, a_ext;
  logic signed [EW-1:0] lim_back, lim_turn, lim_side, lim_pen, goal_fx;
  logic signed [EW-1:0] leg_delta, prog_delta, leg_sum, prog_sum;
  logic signed [ACC_WIDTH-1:0] leg_sat, prog_sat;
  logic done;
  logic spin_cw;
  logic signed [9:0] fs, rs, ts;

  assign d_ext    = EW'(distance_delta);
  assign a_ext    = EW'(angle_delta);
  assign lim_back = signed'(EW'(cfg.backup_mm) << FRAC_BITS);
  assign lim_turn = signed'(EW'(cfg.turn_deg) << FRAC_BITS);
  assign lim_side = signed'(EW'(cfg.sidestep_mm) << FRAC_BITS);
  assign lim_pen  = signed'(EW'(cfg.progress_penalty_mm) << FRAC_BITS);
  assign goal_fx  = signed'(EW'(cur.goal) << FRAC_BITS);

  // Leg accumulator operand by phase and bump side.
  always_comb begin
    case (cur.phase)
      bams_pkg::PH_REV:  leg_delta = -d_ext;
      bams_pkg::PH_AWAY: leg_delta = cur.bump_side ? a_ext : -a_ext;
      bams_pkg::PH_SIDE: leg_delta = d_ext;
      bams_pkg::PH_BACK: leg_delta = cur.bump_side ? -a_ext : a_ext;
      default:           leg_delta = '0;
    endcase
  end

  // Progress grows while driving forward and drops by the penalty after a maneuver.
  assign prog_delta = (cur.phase == bams_pkg::PH_FWD) ? d_ext : -lim_pen;
  assign leg_sum    = EW'(leg_acc) + leg_delta;
  assign prog_sum   = EW'(progress_acc) + prog_delta;
  assign leg_sat    = sat_acc(leg_sum);
  assign prog_sat   = sat_acc(prog_sum);

  // Next state.
  always_comb begin
    nxt           = cur;
    progress_next = progress_acc;
    leg_next      = leg_acc;
    done          = 1'b0;
    if (!operation) begin
      nxt.goal      = target_distance;
      nxt.bump_side = 1'b0;
      progress_next = '0;
      leg_next      = '0;
      if (target_distance == 16'd0) begin
        nxt.phase = bams_pkg::PH_IDLE;
        done      = 1'b1;
      end else begin
        nxt.phase = bams_pkg::PH_FWD;
      end
    end else begin
      unique case (cur.phase)
        bams_pkg::PH_IDLE: ;
        bams_pkg::PH_FWD: begin
          progress_next = prog_sat;
          if (bump_left) begin
            nxt.bump_side = 1'b0;
            leg_next      = '0;
            nxt.phase     = bams_pkg::PH_REV;
          end else if (bump_right) begin
            nxt.bump_side = 1'b1;
            leg_next      = '0;
            nxt.phase     = bams_pkg::PH_REV;
          end else if (EW'(prog_sat) >= goal_fx) begin
            nxt.phase = bams_pkg::PH_IDLE;
            done      = 1'b1;
          end
        end
        bams_pkg::PH_REV: begin
          leg_next = leg_sat;
          if (EW'(leg_sat) >= lim_back) begin
            leg_next  = '0;
            nxt.phase = bams_pkg::PH_AWAY;
          end
        end
        bams_pkg::PH_AWAY: begin
          leg_next = leg_sat;
          if (EW'(leg_sat) >= lim_turn) begin
            leg_next  = '0;
            nxt.phase = bams_pkg::PH_SIDE;
          end
        end
        bams_pkg::PH_SIDE: begin
          leg_next = leg_sat;
          if (EW'(leg_sat) >= lim_side) begin
            leg_next  = '0;
            nxt.phase = bams_pkg::PH_BACK;
          end
        end
        bams_pkg::PH_BACK: begin
          leg_next = leg_sat;
          if (EW'(leg_sat) >= lim_turn) begin
            leg_next      = '0;
            progress_next = prog_sat;
            if (EW'(prog_sat) >= goal_fx) begin
              nxt.phase = bams_pkg::PH_IDLE;
              done      = 1'b1;
            end else begin
              nxt.phase = bams_pkg::PH_FWD;
            end
          end
        end
        default: nxt.phase = bams_pkg::PH_IDLE;
      endcase
    end
  end

  // Outputs follow the phase after this item, so legs hand over without a zero command.
  assign fs = signed'(10'(cfg.forward_speed));
  assign rs = signed'(10'(cfg.reverse_speed));
  assign ts = signed'(10'(cfg.turn_speed));
  assign spin_cw = (nxt.phase == bams_pkg::PH_AWAY) ? !nxt.bump_side : nxt.bump_side;

  always_comb begin
    res.busy  = (nxt.phase != bams_pkg::PH_IDLE);
    res.done  = done;
    res.phase = nxt.phase;
    unique case (nxt.phase)
      bams_pkg::PH_FWD, bams_pkg::PH_SIDE: begin
        res.right_wheel = fs;
        res.left_wheel  = fs;
      end
      bams_pkg::PH_REV: begin
        res.right_wheel = -rs;
        res.left_wheel  = -rs;
      end
      bams_pkg::PH_AWAY, bams_pkg::PH_BACK: begin
        res.right_wheel = spin_cw ? -ts : ts;
        res.left_wheel  = spin_cw ? ts : -ts;
      end
      default: begin
        res.right_wheel = '0;
        res.left_wheel  = '0;
      end
    endcase
  end

endmodule

@@ hdl/bams_out_buf.sv @@
`timescale 1ns / 1ps

module bams_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bams_pkg::result_t push_item,
  output logic              not_full,
  output logic              out_valid,
  input  logic              out_ready,
  output bams_pkg::result_t out_item
);

  // Two-entry queue: the producer keeps going while one result waits downstream.
  bams_pkg::result_t entries [2];
  logic              wr_ptr, rd_ptr;
  logic [1:0]        count;
  logic              pop;

  assign not_full  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign out_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
